[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the IPv4 header check checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define ASSERT_CLKD(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/ipv4hc_pkg.sv]
// ---------------------------------------------------------------------------
// ipv4hc_pkg
// Types, constants and helpers shared by the IPv4 header check modules.
// ---------------------------------------------------------------------------
package ipv4hc_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned IDX_W  = 5;

  localparam logic [15:0] SUM_GOOD      = 16'hffff;
  localparam logic [31:0] BCAST_ADDR    = 32'hffff_ffff;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [3:0]  MIN_IHL       = 4'd5;
  localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;

  // Header word positions of the captured fields.
  localparam logic [IDX_W-1:0] IDX_VER_IHL   = 5'd0;
  localparam logic [IDX_W-1:0] IDX_TOTAL_LEN = 5'd1;
  localparam logic [IDX_W-1:0] IDX_TTL_PROTO = 5'd4;
  localparam logic [IDX_W-1:0] IDX_DEST_HI   = 5'd8;
  localparam logic [IDX_W-1:0] IDX_DEST_LO   = 5'd9;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT   = 3'd0,
    VERDICT_VERSION  = 3'd1,
    VERDICT_HDR_LEN  = 3'd2,
    VERDICT_TTL      = 3'd3,
    VERDICT_CHECKSUM = 3'd4,
    VERDICT_DEST     = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              sop;
  } item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [5:0]  header_bytes;
    logic [15:0] payload_length;
    logic [7:0]  upper_protocol;
  } result_t;

  // One's-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

[rtl/core/ipv4hc_in_stage.sv]
// ---------------------------------------------------------------------------
// ipv4hc_in_stage
// Input register that holds one packet word until the parser takes it.
// ---------------------------------------------------------------------------
module ipv4hc_in_stage
  import ipv4hc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  in_fire;

  assign in_ready = !valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[rtl/core/ipv4hc_hdr_parse.sv]
// ---------------------------------------------------------------------------
// ipv4hc_hdr_parse
// Header field capture, running checksum and verdict for one word a cycle unless the result stalls.
// ---------------------------------------------------------------------------
module ipv4hc_hdr_parse
  import ipv4hc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        item_valid,
  input  item_t       item,
  input  logic        advance,
  output logic        res_valid,
  output result_t     res
);

  logic [IDX_W-1:0] word_index_r;
  logic             header_done_r;
  logic [15:0]      ones_sum_r;
  logic [7:0]       version_ihl_r;
  logic [15:0]      packet_length_r;
  logic [7:0]       hop_limit_r;
  logic [7:0]       proto_field_r;
  logic [31:0]      dest_address_r;
  logic [31:0]      local_address_r;

  logic [IDX_W-1:0] idx;
  logic [15:0]      sum_base, sum_nxt;
  logic             open;
  logic             fire;
  logic [7:0]       version_ihl_nxt;
  logic [15:0]      packet_length_nxt;
  logic [7:0]       hop_limit_nxt;
  logic [7:0]       proto_field_nxt;
  logic [31:0]      dest_address_nxt;
  logic [3:0]       ihl;
  logic [5:0]       hdr_words;
  logic             last;
  logic [5:0]       hbytes;
  verdict_t         verdict;

  // A start flag restarts the header regardless of what was open.
  assign idx      = item.sop ? '0 : word_index_r;
  assign sum_base = item.sop ? 16'd0 : ones_sum_r;
  assign open     = item.sop || !header_done_r;
  assign fire     = item_valid && advance;
  assign sum_nxt  = oc_add(sum_base, item.word);

  always_comb begin
    version_ihl_nxt   = version_ihl_r;
    packet_length_nxt = packet_length_r;
    hop_limit_nxt     = hop_limit_r;
    proto_field_nxt   = proto_field_r;
    dest_address_nxt  = dest_address_r;
    case (idx)
      IDX_VER_IHL:   version_ihl_nxt = item.word[15:8];
      IDX_TOTAL_LEN: packet_length_nxt = item.word;
      IDX_TTL_PROTO: begin
        hop_limit_nxt   = item.word[15:8];
        proto_field_nxt = item.word[7:0];
      end
      IDX_DEST_HI:   dest_address_nxt = {item.word, dest_address_r[15:0]};
      IDX_DEST_LO:   dest_address_nxt = {dest_address_r[31:16], item.word};
      default: ;
    endcase
  end

  // Short IHL values still read a minimum-size header.
  assign ihl       = version_ihl_nxt[3:0];
  assign hdr_words = (ihl < MIN_IHL) ? {1'b0, MIN_IHL, 1'b0} : {1'b0, ihl, 1'b0};
  assign last      = ({1'b0, idx} + 6'd1) >= hdr_words;
  assign hbytes    = {ihl, 2'b00};

  always_comb begin
    if (version_ihl_nxt[7:4] != IP_VERSION) begin
      verdict = VERDICT_VERSION;
    end else if (ihl < MIN_IHL) begin
      verdict = VERDICT_HDR_LEN;
    end else if (hop_limit_nxt == 8'd0) begin
      verdict = VERDICT_TTL;
    end else if (sum_nxt != SUM_GOOD) begin
      verdict = VERDICT_CHECKSUM;
    end else if (dest_address_nxt != local_address_r && dest_address_nxt != BCAST_ADDR) begin
      verdict = VERDICT_DEST;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

  assign res_valid          = item_valid && open && last;
  assign res.verdict        = verdict;
  assign res.header_bytes   = hbytes;
  assign res.payload_length = (packet_length_nxt > {10'b0, hbytes}) ?
                              (packet_length_nxt - {10'b0, hbytes}) : 16'd0;
  assign res.upper_protocol = proto_field_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= '0;
    end else if (cfg_wr_en) begin
      local_address_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r    <= '0;
      header_done_r   <= 1'b1;
      ones_sum_r      <= '0;
      version_ihl_r   <= '0;
      packet_length_r <= '0;
      hop_limit_r     <= '0;
      proto_field_r   <= '0;
      dest_address_r  <= '0;
    end else if (fire && open) begin
      ones_sum_r      <= sum_nxt;
      version_ihl_r   <= version_ihl_nxt;
      packet_length_r <= packet_length_nxt;
      hop_limit_r     <= hop_limit_nxt;
      proto_field_r   <= proto_field_nxt;
      dest_address_r  <= dest_address_nxt;
      if (last) begin
        header_done_r <= 1'b1;
        word_index_r  <= '0;
      end else begin
        header_done_r <= 1'b0;
        word_index_r  <= idx + 1'b1;
      end
    end
  end

endmodule

[rtl/core/ipv4hc_out_stage.sv]
// ---------------------------------------------------------------------------
// ipv4hc_out_stage
// Result register that holds a verdict until the receiver takes it.
// ---------------------------------------------------------------------------
module ipv4hc_out_stage
  import ipv4hc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[rtl/core/ipv4_header_receive_check_core.sv]
// ---------------------------------------------------------------------------
// ipv4_header_receive_check_core
// IPv4 receive header check: field capture, checksum and one verdict a header.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one 16-bit packet word per
//   item, in network byte order, with in_start_of_packet marking the first
//   word of a packet. Words past the end of the header are consumed and
//   dropped. The output channel (out_valid/out_ready) carries one item per
//   header: the verdict, header length in bytes, payload length and the
//   protocol number. The local address is written through cfg_wr_en and
//   cfg_wr_data while no packet is in flight.
//   Throughput is one word per cycle while the receiver keeps up. The input
//   register and the result register sit on either side of a single
//   add-and-compare stage: the last header word is held in the input
//   register, and its verdict is then registered in the result register.
//   When the receiver stalls, the pending verdict holds in the result
//   register and the parse stage stops. One more word is still taken into
//   the input register; after that the input is held off until the verdict
//   is taken, whether the waiting word belongs to a header or to a payload.
//   Reset clears both valid flags, marks no header open and clears the
//   local address to zero.
// ---------------------------------------------------------------------------
module ipv4_header_receive_check_core
  import ipv4hc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_header_word,
  input  logic        in_start_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [5:0]  out_header_bytes,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_upper_protocol
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.word = in_header_word;
  assign in_item.sop  = in_start_of_packet;

  // Input register: one word waits here for the parse stage.
  ipv4hc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Parse stage: header state and the verdict for the final header word.
  ipv4hc_hdr_parse u_hdr_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register: the stage advances whenever it is empty or being drained.
  ipv4hc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_verdict        = out_res.verdict;
  assign out_header_bytes   = out_res.header_bytes;
  assign out_payload_length = out_res.payload_length;
  assign out_upper_protocol = out_res.upper_protocol;

endmodule

[rtl/core/ipv4hc_checker.sv]
// ---------------------------------------------------------------------------
// ipv4hc_checker
// Port-level assertions for the IPv4 header check, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4hc_checker
  import ipv4hc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_verdict,
  input logic [5:0]  out_header_bytes,
  input logic [15:0] out_payload_length,
  input logic [7:0]  out_upper_protocol
);

  // A stalled result must not change.
  `ASSERT_CLKD(a_out_hold, clk, rst_n,
               out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
               $stable(out_header_bytes) && $stable(out_payload_length) &&
               $stable(out_upper_protocol), "stalled result changed")

  // The header length is always a whole number of 32-bit words.
  `ASSERT_CLKD(a_hdr_aligned, clk, rst_n,
               out_valid |-> out_header_bytes[1:0] == 2'b00,
               "header length not word aligned")

  // An accepted header can never be shorter than the minimum.
  `ASSERT_CLKD(a_accept_len, clk, rst_n,
               out_valid && out_verdict == VERDICT_ACCEPT |->
               out_header_bytes >= MIN_HDR_BYTES, "short header accepted")

  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind ipv4_header_receive_check_core ipv4hc_checker u_ipv4hc_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for ipv4_header_receive_check_core. Packets are built
// word by word with a correct checksum or a chosen fault, sent with random
// gaps and a random stall on the verdict side, and every verdict item is
// compared with the one that a cycle-free model of the header check predicts.
// ---------------------------------------------------------------------------
module tb_top;
  import ipv4hc_pkg::*;

  // Words are sent until about this many items have gone in, directed
  // tests included.
  localparam int TOTAL_ITEMS = 1450;
  // Idle margin once the last verdict has been taken, before a register
  // write or the end of the run.
  localparam int SETTLE_CYCLES = 6;
  localparam int unsigned TIMEOUT_NS = 4_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_header_word;
  logic        in_start_of_packet;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_verdict;
  logic [5:0]  out_header_bytes;
  logic [15:0] out_payload_length;
  logic [7:0]  out_upper_protocol;

  ipv4_header_receive_check_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_header_word     (in_header_word),
    .in_start_of_packet (in_start_of_packet),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_header_bytes   (out_header_bytes),
    .out_payload_length (out_payload_length),
    .out_upper_protocol (out_upper_protocol)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the receive state. It follows every accepted word exactly as
  // the block should, so that each verdict can be predicted at the moment
  // the last header word is handed over.
  logic [31:0] local_addr_shadow = 32'h0;
  logic [4:0]  rx_word_idx = 5'd0;
  bit          rx_header_open = 1'b0;
  logic [15:0] rx_sum = 16'h0;
  logic [7:0]  rx_ver_ihl = 8'h0;
  logic [15:0] rx_total_len = 16'h0;
  logic [7:0]  rx_ttl = 8'h0;
  logic [7:0]  rx_proto = 8'h0;
  logic [31:0] rx_dest = 32'h0;

  // Verdicts that the model has produced and the block has not yet given.
  result_t pending_verdicts[$];

  int  items_sent = 0;
  int  error_count = 0;
  bit  in_burst = 1'b0;
  bit  out_burst = 1'b0;

  // One's-complement add; the carry out of bit 15 wraps back into bit 0.
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] t;
    t = {16'h0, a} + {16'h0, b};
    t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
    return t[15:0];
  endfunction

  // Advances the shadow state by one accepted word. A start flag always
  // opens a fresh header, which also drops a header that was still open.
  // Words that arrive with no header open are ignored by the block.
  task automatic track_header_word(input logic [15:0] w, input logic sop);
    int          needed;
    logic [3:0]  ihl;
    logic [5:0]  hbytes;
    result_t     r;
    if (sop) begin
      rx_word_idx = 5'd0;
      rx_sum = 16'h0;
      rx_header_open = 1'b1;
    end
    if (!rx_header_open) return;
    rx_sum = fold_add(rx_sum, w);
    case (rx_word_idx)
      IDX_VER_IHL:   rx_ver_ihl = w[15:8];
      IDX_TOTAL_LEN: rx_total_len = w;
      IDX_TTL_PROTO: begin
        rx_ttl = w[15:8];
        rx_proto = w[7:0];
      end
      IDX_DEST_HI:   rx_dest[31:16] = w;
      IDX_DEST_LO:   rx_dest[15:0] = w;
      default: ;
    endcase
    // A header that claims fewer than five 32-bit words is still read
    // as twenty bytes; otherwise every option word is part of the sum.
    ihl = rx_ver_ihl[3:0];
    needed = (ihl < MIN_IHL) ? 10 : 2 * int'(ihl);
    if (int'(rx_word_idx) + 1 < needed) begin
      rx_word_idx = rx_word_idx + 5'd1;
      return;
    end
    rx_header_open = 1'b0;
    rx_word_idx = 5'd0;
    hbytes = {ihl, 2'b00};
    // Checks in priority order: the first failing one names the verdict.
    if (rx_ver_ihl[7:4] != IP_VERSION) r.verdict = VERDICT_VERSION;
    else if (ihl < MIN_IHL) r.verdict = VERDICT_HDR_LEN;
    else if (rx_ttl == 8'h0) r.verdict = VERDICT_TTL;
    else if (rx_sum != SUM_GOOD) r.verdict = VERDICT_CHECKSUM;
    else if (rx_dest != local_addr_shadow && rx_dest != BCAST_ADDR) r.verdict = VERDICT_DEST;
    else r.verdict = VERDICT_ACCEPT;
    r.header_bytes = hbytes;
    // Payload length bottoms out at zero when the total is too short.
    r.payload_length = (rx_total_len > {10'h0, hbytes}) ? rx_total_len - {10'h0, hbytes}
                                                        : 16'h0;
    r.upper_protocol = rx_proto;
    pending_verdicts.push_back(r);
  endtask

  // Sends one word. Each item may get a random gap of idle cycles first,
  // except during bursts where words go back to back. Valid stays high
  // with a stable payload until the block takes the word.
  task automatic send_word(input logic [15:0] w, input logic sop);
    int gap;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_header_word <= w;
    in_start_of_packet <= sop;
    do @(posedge clk); while (!in_ready);
    track_header_word(w, sop);
    items_sent++;
  endtask

  // Builds a header with random filler in the fields the block does not
  // look at, then fixes the checksum word so that the one's-complement sum
  // over the whole header is all ones. A fault is injected by flipping
  // bits of one word at or after the checksum word; the mask is never all
  // ones, because 0x0000 and 0xffff are the same number in this sum.
  // cut_after >= 0 stops the header early to model a broken packet.
  task automatic send_frame(input logic [3:0] ver, input logic [3:0] ihl,
                            input logic [7:0] ttl, input logic [7:0] proto,
                            input logic [15:0] total_len, input logic [31:0] dst,
                            input int corrupt_at, input int cut_after,
                            input int payload_words);
    logic [15:0] hdr [30];
    int          nwords;
    int          i;
    logic [15:0] s;
    nwords = (ihl < MIN_IHL) ? 10 : 2 * int'(ihl);
    for (i = 0; i < nwords; i++) hdr[i] = 16'($urandom);
    hdr[0] = {ver, ihl, hdr[0][7:0]};
    hdr[1] = total_len;
    hdr[4] = {ttl, proto};
    hdr[5] = 16'h0;
    hdr[8] = dst[31:16];
    hdr[9] = dst[15:0];
    s = 16'h0;
    for (i = 0; i < nwords; i++) s = fold_add(s, hdr[i]);
    hdr[5] = ~s;
    if (corrupt_at >= 0) hdr[corrupt_at] = hdr[corrupt_at] ^ 16'($urandom_range(1, 16'hfffe));
    for (i = 0; i < nwords && (cut_after < 0 || i < cut_after); i++)
      send_word(hdr[i], i == 0);
    repeat (payload_words) send_word(16'($urandom), 1'b0);
  endtask

  // The address register may only change with nothing in flight: an open
  // header is run to its end first, then every verdict has to drain.
  task automatic write_local_address(input logic [31:0] addr);
    while (rx_header_open) send_word(16'($urandom), 1'b0);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    local_addr_shadow = addr;
  endtask

  // Right after reset the local address is zero, so a packet to 0.0.0.0
  // passes, as does the limited broadcast address.
  task automatic test_reset_address();
    send_frame(IP_VERSION, MIN_IHL, 8'd64, 8'd17, 16'd100, 32'h0, -1, -1, 1);
    send_frame(IP_VERSION, MIN_IHL, 8'd1, 8'd6, 16'd20, BCAST_ADDR, -1, -1, 0);
  endtask

  // Most packets carry several faults at once, so that only the priority
  // order decides which verdict comes out.
  task automatic test_verdict_priority();
    logic [31:0] here;
    here = 32'hc0a8_0001;
    write_local_address(here);
    send_frame(4'd6, MIN_IHL, 8'd0, 8'd1, 16'd40, 32'h0a00_0001, 5, -1, 0);
    send_frame(IP_VERSION, 4'd4, 8'd0, 8'd2, 16'd40, here, -1, -1, 0);
    send_frame(IP_VERSION, 4'd0, 8'd9, 8'd3, 16'hffff, here, -1, -1, 0);
    send_frame(IP_VERSION, MIN_IHL, 8'd0, 8'd4, 16'd60, 32'h0a00_0002, 5, -1, 0);
    send_frame(IP_VERSION, MIN_IHL, 8'd255, 8'd5, 16'd60, 32'h0a00_0003, 7, -1, 0);
    send_frame(IP_VERSION, MIN_IHL, 8'd255, 8'd6, 16'd60, 32'h0a00_0004, -1, -1, 0);
    send_frame(IP_VERSION, MIN_IHL, 8'd128, 8'd255, 16'hffff, here, -1, -1, 2);
  endtask

  task automatic test_special_cases();
    int i;
    // Longest header: the checksum has to cover all the option words too.
    send_frame(IP_VERSION, 4'd15, 8'd3, 8'd0, 16'd200, BCAST_ADDR, -1, -1, 0);
    send_frame(IP_VERSION, 4'd15, 8'd3, 8'd0, 16'd200, BCAST_ADDR, 29, -1, 0);
    // An all-zero header fails on its version before the checksum.
    for (i = 0; i < 10; i++) send_word(16'h0, i == 0);
    // A new start in the middle of a header drops that header silently.
    send_frame(IP_VERSION, MIN_IHL, 8'd7, 8'd17, 16'd80, local_addr_shadow, -1, 4, 0);
    send_frame(IP_VERSION, MIN_IHL, 8'd7, 8'd17, 16'd80, local_addr_shadow, -1, -1, 0);
    // Words with no header open are dropped.
    for (i = 0; i < 3; i++) send_word(16'($urandom), 1'b0);
    // Payload length: below, at and just above the header size.
    send_frame(IP_VERSION, MIN_IHL, 8'd5, 8'd1, 16'd10, BCAST_ADDR, -1, -1, 0);
    send_frame(IP_VERSION, MIN_IHL, 8'd5, 8'd1, 16'd20, BCAST_ADDR, -1, -1, 0);
    send_frame(IP_VERSION, MIN_IHL, 8'd5, 8'd1, 16'd21, BCAST_ADDR, -1, -1, 0);
  endtask

  // With the local address all ones only broadcast gets through.
  task automatic test_address_extremes();
    write_local_address(32'hffff_ffff);
    send_frame(IP_VERSION, MIN_IHL, 8'd10, 8'd17, 16'd30, 32'h0, -1, -1, 0);
    send_frame(IP_VERSION, MIN_IHL, 8'd10, 8'd17, 16'd30, 32'h7f00_0001, -1, -1, 0);
    send_frame(IP_VERSION, MIN_IHL, 8'd10, 8'd17, 16'd30, BCAST_ADDR, -1, -1, 0);
  endtask

  // One random packet. Each fault is switched on on its own with a small
  // chance, so about half the packets are clean and the rest mix faults.
  // Now and then the header is cut short or stray words are thrown in.
  task automatic send_random_packet();
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  ttl;
    logic [31:0] dst;
    logic [15:0] total_len;
    int          nwords;
    int          corrupt_at;
    int          cut_after;
    int          i;
    ver = IP_VERSION;
    if ($urandom_range(0, 7) == 0) begin
      do ver = 4'($urandom); while (ver == IP_VERSION);
    end
    ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : MIN_IHL;
    if ($urandom_range(0, 7) == 0) ihl = 4'($urandom_range(0, 4));
    ttl = ($urandom_range(0, 7) == 0) ? 8'h0 : 8'($urandom_range(1, 255));
    dst = $urandom_range(0, 1) ? local_addr_shadow : BCAST_ADDR;
    if ($urandom_range(0, 7) == 0) begin
      do dst = $urandom; while (dst == local_addr_shadow || dst == BCAST_ADDR);
    end
    case ($urandom_range(0, 3))
      0: total_len = 16'($urandom);
      1: total_len = 16'($urandom_range(0, 60));
      2: total_len = 16'hffff;
      default: total_len = 16'({ihl, 2'b00}) + 16'($urandom_range(0, 8));
    endcase
    nwords = (ihl < MIN_IHL) ? 10 : 2 * int'(ihl);
    corrupt_at = ($urandom_range(0, 7) == 0) ? $urandom_range(5, nwords - 1) : -1;
    cut_after = ($urandom_range(0, 15) == 0) ? $urandom_range(1, nwords - 1) : -1;
    send_frame(ver, ihl, ttl, 8'($urandom), total_len, dst, corrupt_at, cut_after,
               $urandom_range(0, 4));
    if ($urandom_range(0, 15) == 0) begin
      for (i = $urandom_range(1, 3); i > 0; i--)
        send_word(16'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // Four phases, each with its own local address, the extremes among them.
  task automatic test_random_traffic();
    int          phase;
    logic [31:0] addr;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        1: addr = 32'hffff_ffff;
        2: addr = 32'h0;
        default: addr = $urandom;
      endcase
      write_local_address(addr);
      while (items_sent < (phase + 1) * TOTAL_ITEMS / 4) send_random_packet();
    end
  endtask

  // Verdict side: a random stall before each item, with bursts where
  // ready stays up. Ready then holds until an item is taken.
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int gap;
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Every verdict item the block gives is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin : check_verdicts
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict item with none expected: verdict %0d", out_verdict);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_verdict != want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_verdict);
          error_count++;
        end
        if (out_header_bytes != want.header_bytes) begin
          $error("header_bytes: expected %0d, got %0d", want.header_bytes, out_header_bytes);
          error_count++;
        end
        if (out_payload_length != want.payload_length) begin
          $error("payload_length: expected %0d, got %0d", want.payload_length,
                 out_payload_length);
          error_count++;
        end
        if (out_upper_protocol != want.upper_protocol) begin
          $error("upper_protocol: expected %0d, got %0d", want.upper_protocol,
                 out_upper_protocol);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 32'h0;
    in_valid <= 1'b0;
    in_header_word <= 16'h0;
    in_start_of_packet <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_address();
    test_verdict_priority();
    test_special_cases();
    test_address_extremes();
    test_random_traffic();

    // Let the last verdicts drain, then give the block a few idle cycles
    // in case anything unexpected is still on its way out.
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ipv4_header_receive_check_core regression: pass");
    end else begin
      $display("ipv4_header_receive_check_core regression: fail");
    end
    $finish;
  end

  // Hard stop for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("ipv4_header_receive_check_core regression: fail");
    $finish;
  end

endmodule
